// ===== hdl/scm_pkg.sv =====
// Shared types, codes and sizing helpers for the sphere contact test core.
// Used by every module of the block; no dependencies.
`default_nettype none
package scm_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int SCALAR_W        = 31;
	localparam int NORMAL_W        = 18;
	localparam int DEPTH_W         = 31;

	localparam logic [1:0] OP_SPHERE    = 2'd0;
	localparam logic [1:0] OP_BOX_START = 2'd1;
	localparam logic [1:0] OP_BOX_AXIS  = 2'd2;

	typedef struct packed {
		logic start;
		logic clr;
	} mac_ctl_t;

	function automatic int mag_w(input int cw);
		return (cw + 2 > SCALAR_W) ? cw + 2 : SCALAR_W;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/scm_mac.sv =====
// Shared signed multiply-accumulate unit, 16 multiplier bits per cycle.
// Depends on scm_pkg for the control struct.
`default_nettype none
module scm_mac import scm_pkg::*; #(
	parameter int MW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mac_ctl_t             ctl,
	input  wire logic signed [MW:0]   opa,
	input  wire logic signed [MW:0]   opb,
	output logic                      done,
	output logic signed [2*MW+1:0]    acc
);
	localparam int ND  = (MW + 15) / 16;
	localparam int BPW = ND * 16;
	localparam int DCW = (ND > 1) ? $clog2(ND) : 1;
	localparam int PW  = 2 * MW;
	localparam int AW  = 2 * MW + 2;

	logic [MW-1:0]  ma_q;
	logic [BPW-1:0] mb_q;
	logic           neg_q;
	logic [PW-1:0]  pr_q;
	logic [DCW-1:0] dig_q;
	logic           run_q;
	logic           fin_q;

	logic signed [MW:0]   na, nb;
	logic [MW+15:0]       part;
	logic signed [AW-1:0] pext;

	assign na   = opa[MW] ? -opa : opa;
	assign nb   = opb[MW] ? -opb : opb;
	assign part = ma_q * mb_q[BPW-1 -: 16];
	assign pext = $signed(AW'(pr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done  <= 1'b0;
			fin_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
			end else if (run_q && dig_q == DCW'(ND - 1)) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
			if (fin_q) begin
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ma_q  <= na[MW-1:0];
			mb_q  <= BPW'(nb[MW-1:0]);
			neg_q <= opa[MW] ^ opb[MW];
			pr_q  <= '0;
			dig_q <= '0;
			if (ctl.clr) begin
				acc <= '0;
			end
		end else if (run_q) begin
			pr_q  <= PW'(pr_q << 16) + PW'(part);
			mb_q  <= mb_q << 16;
			dig_q <= dig_q + DCW'(1);
		end else if (fin_q) begin
			acc <= neg_q ? acc - pext : acc + pext;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/scm_root.sv =====
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on scm_pkg only by convention; no shared types used.
`default_nettype none
module scm_root import scm_pkg::*; #(
	parameter int SQW = 35
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2*SQW-1:0]   radicand,
	output logic                    done,
	output logic [SQW-1:0]          root
);
	localparam int CW = $clog2(SQW + 1);

	logic [2*SQW-1:0] rad_q;
	logic [SQW+1:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [SQW+3:0]   remx, trial;
	logic             take;

	assign remx  = {rem_q, rad_q[2*SQW-1 -: 2]};
	assign trial = {2'b00, root, 2'b01};
	assign take  = remx >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CW'(1)) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root  <= '0;
			cnt_q <= CW'(SQW);
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			cnt_q <= cnt_q - CW'(1);
			if (take) begin
				rem_q <= (SQW+2)'(remx - trial);
				root  <= {root[SQW-2:0], 1'b1};
			end else begin
				rem_q <= remx[SQW+1:0];
				root  <= {root[SQW-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/scm_div.sv =====
// Restoring fraction divider for normal components, one quotient bit per cycle,
// with round half up and clamp to one. Depends on scm_pkg.
`default_nettype none
module scm_div import scm_pkg::*; #(
	parameter int DNW = 35,
	parameter int FB  = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DNW-1:0]   mag,
	input  wire logic [DNW-1:0]   den,
	output logic                  done,
	output logic [FB:0]           quo
);
	localparam int CW = $clog2(FB + 1);

	logic [DNW-1:0] rem_q, den_q;
	logic [FB:0]    q_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic [DNW:0]   rx;
	logic           rge, ge;
	logic [FB+1:0]  qs;

	assign ge  = mag >= den;
	assign rx  = {rem_q, 1'b0};
	assign rge = rx >= {1'b0, den_q};
	assign qs  = (FB+2)'(q_q) + (FB+2)'(rge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '0) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			q_q   <= (FB+1)'(ge);
			rem_q <= ge ? mag - den : mag;
			cnt_q <= CW'(FB);
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= rge ? DNW'(rx - {1'b0, den_q}) : rx[DNW-1:0];
				q_q   <= {q_q[FB-1:0], rge};
				cnt_q <= cnt_q - CW'(1);
			end else begin
				quo <= (qs > ((FB+2)'(1) << FB)) ? ((FB+1)'(1) << FB) : qs[FB:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sphere_contact_test_core.sv =====
// Sphere contact test core: sphere-sphere and sphere-box tests in fixed point.
// Depends on scm_pkg, scm_mac, scm_root and scm_div.
//
// Input channel: in_valid/in_stall with operation, vec_a_*, vec_b_*, scalar_a,
// scalar_b. A word is taken when in_valid is high and in_stall low. Output
// channel: out_valid/out_stall with collide, normal_*, depth.
// A sphere-sphere word (operation 0) gives one result. A box test is a start
// word (operation 1) and three axis words (operation 2); the third axis word
// gives the result. Operation 3 is dropped.
// in_stall is high while a word is in work; one word is handled at a time.
// Every product runs through one shared multiplier at 16 bits per cycle.
// Reset clears the box state (centre, radius, offset, closest point, axis count)
// to zero. When the receiver stalls, the result holds in the output register;
// the next word is still taken and its result waits until the register frees.
`default_nettype none
module sphere_contact_test_core import scm_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [COORD_WIDTH-1:0] vec_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] vec_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] vec_a_z,
	input  wire logic signed [COORD_WIDTH-1:0] vec_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] vec_b_y,
	input  wire logic signed [COORD_WIDTH-1:0] vec_b_z,
	input  wire logic [SCALAR_W-1:0]           scalar_a,
	input  wire logic [SCALAR_W-1:0]           scalar_b,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               collide,
	output logic signed [NORMAL_W-1:0]         normal_x,
	output logic signed [NORMAL_W-1:0]         normal_y,
	output logic signed [NORMAL_W-1:0]         normal_z,
	output logic [DEPTH_W-1:0]                 depth
);
	localparam int CW  = COORD_WIDTH;
	localparam int MW  = mag_w(CW);
	localparam int AW  = 2 * MW + 2;
	localparam int SQW = MW + 1;
	localparam int DW  = CW + 3;
	localparam int OW  = ((SQW > 33) ? SQW : 33) + 2;
	localparam int NXW = (FRAC_BITS + 2 > NORMAL_W) ? FRAC_BITS + 2 : NORMAL_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_MWAIT = 4'd2;
	localparam logic [3:0] ST_DIFF  = 4'd3;
	localparam logic [3:0] ST_ROOT  = 4'd4;
	localparam logic [3:0] ST_RWAIT = 4'd5;
	localparam logic [3:0] ST_DEPTH = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_DWAIT = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	localparam logic [1:0] PH_DOT = 2'd0;
	localparam logic [1:0] PH_SCL = 2'd1;
	localparam logic [1:0] PH_R2  = 2'd2;
	localparam logic [1:0] PH_SQR = 2'd3;

	localparam logic [AW-1:0] CLIM_U = (AW'(1) << (CW + 1)) - AW'(1);
	localparam logic signed [DW-1:0] CLIM_S = $signed((DW'(1) << (CW + 1)) - DW'(1));
	localparam logic signed [OW-1:0] DMAX = $signed(OW'({DEPTH_W{1'b1}}));

	logic [3:0] st_q;
	logic [1:0] phase_q, idx_q, cnt_q;
	logic [1:0] op_q;

	logic signed [CW-1:0]   a_q [3];
	logic [SCALAR_W-1:0]    sa_q, sb_q, rad_q;
	logic signed [CW-1:0]   cen_q [3];
	logic signed [CW:0]     off_q [3];
	logic signed [CW+1:0]   clp_q [3];
	logic signed [DW-1:0]   d_q [3];
	logic signed [31:0]     proj_q;
	logic signed [AW-1:0]   r2_q;
	logic [SQW-1:0]         dist_q;

	logic                        res_col_q;
	logic signed [NORMAL_W-1:0]  res_n_q [3];
	logic [DEPTH_W-1:0]          res_dep_q;
	logic                        ovalid_q;

	logic signed [CW-1:0] in_a [3];
	logic signed [CW-1:0] in_b [3];

	mac_ctl_t             mac_ctl;
	logic signed [MW:0]   mac_a, mac_b;
	logic                 mac_done;
	logic signed [AW-1:0] acc;
	logic                 root_done;
	logic [SQW-1:0]       root;
	logic                 div_start, div_done;
	logic [SQW-1:0]       div_mag;
	logic [FRAC_BITS:0]   quo;

	logic                 sneg;
	logic [AW-1:0]        smag, sv, cv;
	logic signed [DW-1:0] tmag, csum, cclamp;
	logic signed [31:0]   proj_n;
	logic signed [DW-1:0] dabs;
	logic signed [OW-1:0] ov, bx;
	logic signed [NXW-1:0] nfull, nunit;

	assign in_a[0] = vec_a_x;
	assign in_a[1] = vec_a_y;
	assign in_a[2] = vec_a_z;
	assign in_b[0] = vec_b_x;
	assign in_b[1] = vec_b_y;
	assign in_b[2] = vec_b_z;

	assign in_stall  = st_q != ST_IDLE;
	assign out_valid = ovalid_q;

	always_comb begin
		mac_ctl.start = st_q == ST_MUL;
		mac_ctl.clr   = 1'b1;
		case (phase_q)
			PH_DOT: begin
				mac_a       = (MW+1)'(off_q[idx_q]);
				mac_b       = (MW+1)'(a_q[idx_q]);
				mac_ctl.clr = idx_q == 2'd0;
			end
			PH_SCL: begin
				mac_a = (MW+1)'(a_q[idx_q]);
				mac_b = (MW+1)'(proj_q);
			end
			PH_R2: begin
				mac_a = $signed((MW+1)'(rad_q));
				mac_b = $signed((MW+1)'(rad_q));
			end
			default: begin
				mac_a       = (MW+1)'(d_q[idx_q]);
				mac_b       = (MW+1)'(d_q[idx_q]);
				mac_ctl.clr = idx_q == 2'd0;
			end
		endcase
	end

	always_comb begin
		sneg   = acc[AW-1];
		smag   = sneg ? $unsigned(-acc) : $unsigned(acc);
		sv     = smag >> FRAC_BITS;
		proj_n = (sv > AW'(sa_q)) ? $signed(32'(sa_q)) : $signed(32'(sv));
		if (sneg) begin
			proj_n = -proj_n;
		end
		cv     = (sv > CLIM_U) ? CLIM_U : sv;
		tmag   = $signed(DW'(cv));
		csum   = $signed(DW'(clp_q[idx_q])) + (sneg ? -tmag : tmag);
		if (csum > CLIM_S) begin
			cclamp = CLIM_S;
		end else if (csum < -CLIM_S) begin
			cclamp = -CLIM_S;
		end else begin
			cclamp = csum;
		end
		dabs    = d_q[idx_q][DW-1] ? -d_q[idx_q] : d_q[idx_q];
		div_mag = SQW'(dabs[DW-2:0]);
		ov      = $signed(OW'(sa_q)) + $signed(OW'(sb_q)) - $signed(OW'(dist_q));
		bx      = $signed(OW'(rad_q)) - $signed(OW'(dist_q));
		nfull   = $signed(NXW'(quo));
		if (d_q[idx_q][DW-1]) begin
			nfull = -nfull;
		end
		nunit   = $signed(NXW'(1) << FRAC_BITS);
	end

	assign div_start = st_q == ST_DIV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			phase_q  <= PH_DOT;
			idx_q    <= 2'd0;
			cnt_q    <= 2'd0;
			ovalid_q <= 1'b0;
			rad_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				cen_q[i] <= '0;
				off_q[i] <= '0;
				clp_q[i] <= '0;
			end
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (operation)
							OP_SPHERE: begin
								phase_q <= PH_SQR;
								idx_q   <= 2'd0;
								st_q    <= ST_MUL;
							end
							OP_BOX_START: begin
								for (int i = 0; i < 3; i++) begin
									cen_q[i] <= in_a[i];
									off_q[i] <= (CW+1)'(in_a[i]) - (CW+1)'(in_b[i]);
									clp_q[i] <= (CW+2)'(in_b[i]);
								end
								rad_q <= scalar_a;
								cnt_q <= 2'd0;
							end
							OP_BOX_AXIS: begin
								phase_q <= PH_DOT;
								idx_q   <= 2'd0;
								st_q    <= ST_MUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					st_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mac_done) begin
						st_q  <= ST_MUL;
						idx_q <= idx_q + 2'd1;
						case (phase_q)
							PH_DOT: begin
								if (idx_q == 2'd2) begin
									phase_q <= PH_SCL;
									idx_q   <= 2'd0;
								end
							end
							PH_SCL: begin
								clp_q[idx_q] <= cclamp[CW+1:0];
								if (idx_q == 2'd2) begin
									if (cnt_q == 2'd2) begin
										cnt_q <= 2'd0;
										st_q  <= ST_DIFF;
									end else begin
										cnt_q <= cnt_q + 2'd1;
										st_q  <= ST_IDLE;
									end
								end
							end
							PH_R2: begin
								phase_q <= PH_SQR;
								idx_q   <= 2'd0;
							end
							default: begin
								if (idx_q == 2'd2) begin
									if (op_q == OP_SPHERE || acc < r2_q) begin
										st_q <= ST_ROOT;
									end else begin
										st_q <= ST_OUT;
									end
								end
							end
						endcase
					end
				end
				ST_DIFF: begin
					phase_q <= PH_R2;
					idx_q   <= 2'd0;
					st_q    <= ST_MUL;
				end
				ST_ROOT: begin
					st_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (root_done) begin
						st_q <= ST_DEPTH;
					end
				end
				ST_DEPTH: begin
					idx_q <= 2'd0;
					if (op_q == OP_SPHERE && ov < 0) begin
						st_q <= ST_OUT;
					end else if (dist_q == '0) begin
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					st_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						idx_q <= idx_q + 2'd1;
						st_q  <= (idx_q == 2'd2) ? ST_OUT : ST_DIV;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q <= operation;
					sa_q <= scalar_a;
					sb_q <= scalar_b;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= in_a[i];
						d_q[i] <= DW'(in_b[i]) - DW'(in_a[i]);
					end
				end
			end
			ST_MWAIT: begin
				if (mac_done) begin
					if (phase_q == PH_DOT && idx_q == 2'd2) begin
						proj_q <= proj_n;
					end
					if (phase_q == PH_R2) begin
						r2_q <= acc;
					end
					if (phase_q == PH_SQR && idx_q == 2'd2) begin
						res_col_q <= 1'b0;
						res_dep_q <= '0;
						for (int i = 0; i < 3; i++) begin
							res_n_q[i] <= '0;
						end
					end
				end
			end
			ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= DW'(clp_q[i]) - DW'(cen_q[i]);
				end
			end
			ST_RWAIT: begin
				if (root_done) begin
					dist_q <= root;
				end
			end
			ST_DEPTH: begin
				if (!(op_q == OP_SPHERE && ov < 0)) begin
					res_col_q <= 1'b1;
					if (op_q == OP_SPHERE) begin
						res_dep_q <= (ov > DMAX) ? {DEPTH_W{1'b1}} : ov[DEPTH_W-1:0];
					end else if (bx < 0) begin
						res_dep_q <= '0;
					end else begin
						res_dep_q <= (bx > DMAX) ? {DEPTH_W{1'b1}} : bx[DEPTH_W-1:0];
					end
					res_n_q[0] <= nunit[NORMAL_W-1:0];
					res_n_q[1] <= '0;
					res_n_q[2] <= '0;
				end
			end
			ST_DWAIT: begin
				if (div_done) begin
					res_n_q[idx_q] <= nfull[NORMAL_W-1:0];
				end
			end
			ST_OUT: begin
				if (!ovalid_q || !out_stall) begin
					collide  <= res_col_q;
					normal_x <= res_n_q[0];
					normal_y <= res_n_q[1];
					normal_z <= res_n_q[2];
					depth    <= res_dep_q;
				end
			end
			default: begin
			end
		endcase
	end

	scm_mac #(.MW(MW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.opa    (mac_a),
		.opb    (mac_b),
		.done   (mac_done),
		.acc    (acc)
	);

	scm_root #(.SQW(SQW)) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == ST_ROOT),
		.radicand ($unsigned(acc)),
		.done     (root_done),
		.root     (root)
	);

	scm_div #(.DNW(SQW), .FB(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (dist_q),
		.done   (div_done),
		.quo    (quo)
	);

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(!ovalid_q ##1 ovalid_q) |-> $past(st_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_mac_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> st_q == ST_MWAIT)
		else $error("multiplier finished while sequencer not waiting");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("axis count out of range");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_BOX_START) |=> cnt_q == 2'd0)
		else $error("box start did not clear axis count");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for sphere_contact_test_core: directed and random words,
// checked against a bit-exact predictor. Depends on scm_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;
	import scm_pkg::*;

	localparam longint CLOSE_LIM = (64'd1 << 33) - 1;
	localparam longint DEPTH_MAX = 64'h7FFF_FFFF;
	localparam longint ONE_Q     = 64'd1 << 16;
	localparam int     LIMIT     = 1_000_000;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic [SCALAR_W-1:0] sa;
		logic [SCALAR_W-1:0] sb;
	} word_t;

	typedef struct packed {
		logic collide;
		logic signed [NORMAL_W-1:0] nx;
		logic signed [NORMAL_W-1:0] ny;
		logic signed [NORMAL_W-1:0] nz;
		logic [DEPTH_W-1:0] depth;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = OP_SPHERE;
	logic signed [31:0] vec_a_x = '0, vec_a_y = '0, vec_a_z = '0;
	logic signed [31:0] vec_b_x = '0, vec_b_y = '0, vec_b_z = '0;
	logic [SCALAR_W-1:0] scalar_a = '0, scalar_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic collide;
	logic signed [NORMAL_W-1:0] normal_x, normal_y, normal_z;
	logic [DEPTH_W-1:0] depth;

	sphere_contact_test_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	longint box_sphere [3];
	longint box_radius;
	longint box_offset [3];
	longint box_closest [3];
	int unsigned box_axes;

	contact_t expected_contacts [$];
	int errors = 0;
	int checked = 0;
	int hits = 0;
	int words_sent = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [63:0] isqrt_wide(input logic [127:0] s);
		logic [63:0] r, c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if (!(s < ({64'd0, c} * {64'd0, c})))
				r = c;
		end
		return r;
	endfunction

	function automatic longint unit_div(input longint mag, input longint den);
		longint q, rem;
		q = (mag >= den) ? 64'sd1 : 64'sd0;
		rem = mag - q * den;
		for (int i = 0; i < 16; i++) begin
			rem = rem <<< 1;
			q = q <<< 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		rem = rem <<< 1;
		if (rem >= den)
			q++;
		if (q > ONE_Q)
			q = ONE_Q;
		return q;
	endfunction

	function automatic longint scale_sat(input logic signed [127:0] x, input longint lim);
		logic signed [127:0] m;
		logic neg;
		neg = x < 0;
		m = neg ? -x : x;
		m = m >>> 16;
		if (m > lim)
			m = 128'(lim);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic contact_t make_contact(input longint d [3], input longint dlen,
			input longint dep);
		contact_t r;
		longint n [3];
		for (int i = 0; i < 3; i++) begin
			if (dlen == 0)
				n[i] = (i == 0) ? ONE_Q : 64'sd0;
			else
				n[i] = (d[i] < 0) ? -unit_div(-d[i], dlen) : unit_div(d[i], dlen);
		end
		if (dep < 0)
			dep = 0;
		if (dep > DEPTH_MAX)
			dep = DEPTH_MAX;
		r.collide = 1'b1;
		r.nx = n[0][NORMAL_W-1:0];
		r.ny = n[1][NORMAL_W-1:0];
		r.nz = n[2][NORMAL_W-1:0];
		r.depth = dep[DEPTH_W-1:0];
		return r;
	endfunction

	task automatic predict_contact(input word_t w);
		longint d [3];
		logic signed [127:0] s, t, dot;
		longint dlen, proj, c;
		s = '0;
		dot = '0;
		case (w.op)
			OP_SPHERE: begin
				for (int i = 0; i < 3; i++) begin
					d[i] = longint'(w.b[i]) - longint'(w.a[i]);
					t = 128'(d[i]);
					s += t * t;
				end
				dlen = longint'(isqrt_wide(s));
				if (longint'(w.sa) + longint'(w.sb) - dlen < 0)
					expected_contacts.push_back('0);
				else
					expected_contacts.push_back(make_contact(d, dlen,
						longint'(w.sa) + longint'(w.sb) - dlen));
			end
			OP_BOX_START: begin
				for (int i = 0; i < 3; i++) begin
					box_sphere[i] = longint'(w.a[i]);
					box_offset[i] = longint'(w.a[i]) - longint'(w.b[i]);
					box_closest[i] = longint'(w.b[i]);
				end
				box_radius = longint'(w.sa);
				box_axes = 0;
			end
			OP_BOX_AXIS: begin
				for (int i = 0; i < 3; i++) begin
					t = 128'(box_offset[i]);
					dot += t * 128'(w.a[i]);
				end
				proj = scale_sat(dot, longint'(w.sa));
				for (int i = 0; i < 3; i++) begin
					t = 128'(proj);
					c = box_closest[i] + scale_sat(128'(w.a[i]) * t, CLOSE_LIM);
					if (c > CLOSE_LIM)
						c = CLOSE_LIM;
					if (c < -CLOSE_LIM)
						c = -CLOSE_LIM;
					box_closest[i] = c;
				end
				box_axes = (box_axes + 1) & 3;
				if (box_axes == 3) begin
					box_axes = 0;
					for (int i = 0; i < 3; i++) begin
						d[i] = box_closest[i] - box_sphere[i];
						t = 128'(d[i]);
						s += t * t;
					end
					t = 128'(box_radius);
					if (s < t * t) begin
						dlen = longint'(isqrt_wide(s));
						expected_contacts.push_back(make_contact(d, dlen, box_radius - dlen));
					end else begin
						expected_contacts.push_back('0);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input word_t w);
		operation <= w.op;
		vec_a_x <= w.a[0];
		vec_a_y <= w.a[1];
		vec_a_z <= w.a[2];
		vec_b_x <= w.b[0];
		vec_b_y <= w.b[1];
		vec_b_z <= w.b[2];
		scalar_a <= w.sa;
		scalar_b <= w.sb;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_contact(w);
		words_sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic word_t mk(input logic [1:0] op, input longint ax, ay, az,
			input longint bx, by, bz, input longint sa, sb);
		word_t w;
		w.op = op;
		w.a[0] = 32'(ax); w.a[1] = 32'(ay); w.a[2] = 32'(az);
		w.b[0] = 32'(bx); w.b[1] = 32'(by); w.b[2] = 32'(bz);
		w.sa = SCALAR_W'(sa);
		w.sb = SCALAR_W'(sb);
		return w;
	endfunction

	function automatic logic signed [31:0] rnd_coord();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [SCALAR_W-1:0] rnd_scalar();
		return SCALAR_W'($urandom >> $urandom_range(1, 31));
	endfunction

	function automatic word_t rnd_word(input logic [1:0] op);
		word_t w;
		w.op = op;
		for (int i = 0; i < 3; i++) begin
			w.a[i] = rnd_coord();
			w.b[i] = rnd_coord();
		end
		w.sa = rnd_scalar();
		w.sb = rnd_scalar();
		return w;
	endfunction

	task automatic send_box(input word_t start);
		word_t w;
		int perm;
		perm = $urandom_range(0, 2);
		send_word(start);
		for (int k = 0; k < 3; k++) begin
			w = rnd_word(OP_BOX_AXIS);
			if ($urandom_range(3) != 0) begin
				for (int i = 0; i < 3; i++)
					w.a[i] = (i == (k + perm) % 3) ?
						32'($urandom_range(1) ? ONE_Q : -ONE_Q) : 32'sd0;
			end else if ($urandom_range(1)) begin
				for (int i = 0; i < 3; i++)
					w.a[i] = 32'($signed(longint'($urandom_range(0, 2 * ONE_Q))) - ONE_Q);
			end
			send_word(w);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (expected_contacts.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic test_stray_axes();
		send_word(mk(OP_BOX_AXIS, ONE_Q, 0, 0, 0, 0, 0, 100, 0));
		send_word(mk(OP_BOX_AXIS, 0, ONE_Q, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_BOX_AXIS, 0, 0, -ONE_Q, 0, 0, 0, 2147483647, 0));
		drain();
	endtask

	task automatic test_sphere_directed();
		send_word(mk(OP_SPHERE, 5, 5, 5, 5, 5, 5, 0, 0));
		send_word(mk(OP_SPHERE, 0, 0, 0, 3 * ONE_Q, 4 * ONE_Q, 0, 2 * ONE_Q, 3 * ONE_Q));
		send_word(mk(OP_SPHERE, 0, 0, 0, 3 * ONE_Q, 4 * ONE_Q, 0, ONE_Q, 3 * ONE_Q));
		send_word(mk(OP_SPHERE, -2147483648, -2147483648, -2147483648,
			2147483647, 2147483647, 2147483647, 2147483647, 2147483647));
		send_word(mk(OP_SPHERE, 2147483647, 0, -2147483648,
			-2147483648, 0, 2147483647, 2147483647, 2147483647));
		send_word(mk(OP_SPHERE, 0, 0, 0, 0, 0, 0, 2147483647, 2147483647));
		send_word(mk(OP_SPHERE, 0, 0, 0, -ONE_Q, 0, 0, ONE_Q, 0));
		drain();
	endtask

	task automatic test_box_directed();
		word_t ax [3];
		ax[0] = mk(OP_BOX_AXIS, ONE_Q, 0, 0, 0, 0, 0, 2 * ONE_Q, 0);
		ax[1] = mk(OP_BOX_AXIS, 0, ONE_Q, 0, 0, 0, 0, 2 * ONE_Q, 0);
		ax[2] = mk(OP_BOX_AXIS, 0, 0, ONE_Q, 0, 0, 0, 2 * ONE_Q, 0);
		// sphere at box centre, then overlapping, touching and clear of the box
		send_word(mk(OP_BOX_START, 0, 0, 0, 0, 0, 0, ONE_Q, 0));
		foreach (ax[i]) send_word(ax[i]);
		send_word(mk(OP_BOX_START, 3 * ONE_Q, 0, 0, 0, 0, 0, 2 * ONE_Q, 0));
		foreach (ax[i]) send_word(ax[i]);
		send_word(mk(OP_BOX_START, -3 * ONE_Q, 0, 0, 0, 0, 0, ONE_Q, 0));
		foreach (ax[i]) send_word(ax[i]);
		send_word(mk(OP_BOX_START, 10 * ONE_Q, 10 * ONE_Q, 0, 0, 0, 0, ONE_Q, 0));
		foreach (ax[i]) send_word(ax[i]);
		// keep adding axes after the answer
		foreach (ax[i]) send_word(ax[i]);
		send_word(mk(OP_BOX_START, 2147483647, -2147483648, 2147483647,
			-2147483648, 2147483647, -2147483648, 2147483647, 0));
		send_word(mk(OP_BOX_AXIS, -2147483648, 2147483647, -2147483648, 0, 0, 0,
			2147483647, 0));
		send_word(mk(OP_BOX_AXIS, 2147483647, 2147483647, 2147483647, 0, 0, 0,
			2147483647, 0));
		send_word(mk(OP_BOX_AXIS, -2147483648, -2147483648, 2147483647, 0, 0, 0,
			2147483647, 0));
		send_word(mk(OP_IGNORED, 1, 2, 3, 4, 5, 6, 7, 8));
		drain();
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		word_t w;
		int sel;
		idle_pct = idle;
		stall_pct = stall;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			if (sel < 35) begin
				w = rnd_word(OP_SPHERE);
				if ($urandom_range(1))
					for (int i = 0; i < 3; i++)
						w.b[i] = w.a[i] + ($signed($urandom) >>> $urandom_range(8, 31));
				send_word(w);
			end else if (sel < 85) begin
				w = rnd_word(OP_BOX_START);
				if ($urandom_range(1))
					for (int i = 0; i < 3; i++)
						w.a[i] = w.b[i] + ($signed($urandom) >>> $urandom_range(8, 31));
				send_box(w);
				k += 3;
			end else if (sel < 92) begin
				send_word(rnd_word(OP_BOX_AXIS));
			end else if (sel < 96) begin
				send_word(rnd_word(OP_BOX_START));
			end else begin
				send_word(rnd_word(OP_IGNORED));
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 800;
		for (int k = 0; k < 6; k++)
			send_word(rnd_word(OP_SPHERE));
		in_valid <= 1'b0;
		wait (expected_contacts.size() == 0);
		send_box(rnd_word(OP_BOX_START));
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
	endtask

	always @(posedge clk) begin
		contact_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_contacts.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = expected_contacts.pop_front();
				if (collide !== want.collide) report("collide", collide, want.collide);
				if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
				if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
				if (normal_z !== want.nz) report("normal_z", normal_z, want.nz);
				if (depth !== want.depth) report("depth", depth, want.depth);
				hits += want.collide;
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stray_axes();
		test_sphere_directed();
		test_box_directed();
		test_random(200, 0, 0);
		test_random(200, 67, 0);
		test_random(200, 0, 67);
		test_random(200, 37, 37);
		test_backpressure();
		if (expected_contacts.size() != 0)
			report("results left over", expected_contacts.size(), 0);
		$display("%0d words sent, %0d results checked, %0d in contact, %0d cycles",
			words_sent, checked, hits, cycles);
		$display("sphere and box tests under sender gaps, receiver stalls and hold-off");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
